[hw/rtl/crs_pkg.sv]
`default_nettype none
package crs_pkg;

  localparam int NUM_CLASSES = 6;
  localparam int COUNT_BITS  = 24;
  localparam int SCORE_BITS  = 16;

  localparam int SCORE_FIELDS  = 6;
  localparam int SCORE_FIELD_W = 16;
  localparam int SCORE_W       = SCORE_FIELD_W + 1;
  localparam int SCORE_USED    = (SCORE_BITS < SCORE_FIELD_W) ? SCORE_BITS : SCORE_FIELD_W;
  localparam int CLASS_W       = 3;
  localparam int LOSS_W        = 16;
  localparam int SQ_IN_W       = 2 * LOSS_W;
  localparam int OUT_CNT_W     = 24;
  localparam int SUM_W         = 40;
  localparam int SQ_W          = 56;
  localparam int CELLS         = NUM_CLASSES * NUM_CLASSES;
  localparam int CELL_AW       = $clog2(CELLS);

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [CLASS_W-1:0]        cls_t;
  typedef logic [COUNT_BITS-1:0]     cnt_t;
  typedef logic [CELL_AW-1:0]        addr_t;

  localparam cnt_t CNT_MAX = '1;

  typedef struct packed {
    cls_t  pred;
    cls_t  rank;
    logic  correct;
    logic  label_ok;
    addr_t addr;
  } rank_res_t;

  typedef struct packed {
    cnt_t              tests;
    cnt_t              corrects;
    logic [LOSS_W-1:0] min_loss;
    logic [LOSS_W-1:0] max_loss;
    logic [SUM_W-1:0]  sum_loss;
    logic [SQ_W-1:0]   sum_sq;
  } stats_t;

  // Low SCORE_BITS of the field, sign-extended; wider settings see the field as unsigned.
  function automatic score_t score_val(input logic [SCORE_FIELD_W-1:0] raw);
    logic [SCORE_W-1:0] ext;
    score_t             v;
    ext = {1'b0, raw};
    for (int b = 0; b < SCORE_W; b++) begin
      if (b < SCORE_USED) begin
        v[b] = ext[b];
      end else begin
        v[b] = (SCORE_BITS <= SCORE_FIELD_W) ? ext[SCORE_USED-1] : 1'b0;
      end
    end
    return v;
  endfunction

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == CNT_MAX) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage
`default_nettype wire

[hw/rtl/crs_in_if.sv]
`default_nettype none
interface crs_in_if;
  import crs_pkg::*;

  logic                            valid;
  logic                            ready;
  logic signed [SCORE_FIELD_W-1:0] score_0;
  logic signed [SCORE_FIELD_W-1:0] score_1;
  logic signed [SCORE_FIELD_W-1:0] score_2;
  logic signed [SCORE_FIELD_W-1:0] score_3;
  logic signed [SCORE_FIELD_W-1:0] score_4;
  logic signed [SCORE_FIELD_W-1:0] score_5;
  logic [CLASS_W-1:0]              true_label;
  logic [LOSS_W-1:0]               loss;

  modport source (
    output valid, score_0, score_1, score_2, score_3, score_4, score_5, true_label, loss,
    input  ready
  );
  modport sink (
    input  valid, score_0, score_1, score_2, score_3, score_4, score_5, true_label, loss,
    output ready
  );
endinterface
`default_nettype wire

[hw/rtl/crs_out_if.sv]
`default_nettype none
interface crs_out_if;
  import crs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CLASS_W-1:0]   predicted_class;
  logic [CLASS_W-1:0]   true_rank;
  logic                 is_correct;
  logic [OUT_CNT_W-1:0] cell_count;
  logic [OUT_CNT_W-1:0] tests_total;
  logic [OUT_CNT_W-1:0] correct_total;
  logic [LOSS_W-1:0]    lowest_loss;
  logic [LOSS_W-1:0]    highest_loss;
  logic [SUM_W-1:0]     loss_total;
  logic [SQ_W-1:0]      loss_square_total;

  modport source (
    output valid, predicted_class, true_rank, is_correct, cell_count, tests_total,
           correct_total, lowest_loss, highest_loss, loss_total, loss_square_total,
    input  ready
  );
  modport sink (
    input  valid, predicted_class, true_rank, is_correct, cell_count, tests_total,
           correct_total, lowest_loss, highest_loss, loss_total, loss_square_total,
    output ready
  );
endinterface
`default_nettype wire

[hw/rtl/classifier_rank_statistics.sv]
// Each word passes the input register and the counter stage into the result register.
// Throughput: one word per cycle while result.ready holds; three-stage pipeline (input
//   register, counter read-modify-write stage, result register) with forwarding on the
//   counter RAM. Reset (synchronous, rst high): empties the pipeline, clears all
//   statistics and marks every rank/label cell invalid; invalid cells read as zero.
`default_nettype none
module classifier_rank_statistics (
  input wire logic clk,
  input wire logic rst,
  crs_in_if.sink   item,
  crs_out_if.source result
);
  import crs_pkg::*;

  // ---------------- stage A: input register ----------------
  logic                     a_valid;
  logic [SCORE_FIELD_W-1:0] a_raw [SCORE_FIELDS];
  cls_t                     a_label;
  logic [LOSS_W-1:0]        a_loss;
  score_t                   a_s [NUM_CLASSES];
  rank_res_t                a_res;

  // ---------------- stage B: counter update ----------------
  logic               b_valid;
  rank_res_t          b_res;
  logic [LOSS_W-1:0]  b_loss;
  logic [SQ_IN_W-1:0] b_sq;

  // ---------------- stage C: result register ----------------
  logic c_valid;

  // handshake / advance
  logic b_load;
  logic c_load;

  // rank matrix storage
  addr_t           raddr;
  logic            we;
  cnt_t            rdata;
  logic            cell_valid [CELLS];
  logic            rd_ok;
  logic            fw_hit;
  cnt_t            fw_data;
  cnt_t            cell_old;
  cnt_t            cell_new;
  stats_t          st_next;

  assign c_load     = b_valid && (!c_valid || result.ready);
  assign b_load     = a_valid && (!b_valid || c_load);
  assign item.ready = !a_valid || b_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (item.ready) begin
      a_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      a_raw[0] <= item.score_0;
      a_raw[1] <= item.score_1;
      a_raw[2] <= item.score_2;
      a_raw[3] <= item.score_3;
      a_raw[4] <= item.score_4;
      a_raw[5] <= item.score_5;
      a_label  <= item.true_label;
      a_loss   <= item.loss;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      a_s[i] = score_val(a_raw[i]);
    end
  end

  crs_rank u_rank (
    .s     (a_s),
    .label (a_label),
    .res   (a_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_valid || c_load) begin
      b_valid <= a_valid;
    end
  end

  // square is registered here so the wide accumulate sees a flop output
  always_ff @(posedge clk) begin
    if (b_load) begin
      b_res  <= a_res;
      b_loss <= a_loss;
      b_sq   <= SQ_IN_W'(a_loss) * SQ_IN_W'(a_loss);
    end
  end

  // Read the address of whatever sits in B next cycle; a held B re-reads its own cell.
  assign raddr = b_load ? a_res.addr : b_res.addr;
  assign we    = c_load && b_res.label_ok;

  crs_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (b_res.addr),
    .wdata (cell_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  // valid bits stand in for clearing the matrix
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        cell_valid[i] <= 1'b0;
      end
      rd_ok  <= 1'b0;
      fw_hit <= 1'b0;
    end else begin
      if (we) begin
        cell_valid[b_res.addr] <= 1'b1;
      end
      rd_ok  <= cell_valid[raddr];
      fw_hit <= we && (b_res.addr == raddr);
    end
  end

  // write and read of one cell on the same edge: RAM returns the old value
  always_ff @(posedge clk) begin
    if (we) begin
      fw_data <= cell_new;
    end
  end

  assign cell_old = fw_hit ? fw_data : (rd_ok ? rdata : '0);
  assign cell_new = sat_inc(cell_old);

  crs_stats u_stats (
    .clk      (clk),
    .rst      (rst),
    .upd      (c_load),
    .label_ok (b_res.label_ok),
    .correct  (b_res.correct),
    .loss     (b_loss),
    .sq       (b_sq),
    .nxt      (st_next)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (!c_valid || result.ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      result.predicted_class   <= b_res.pred;
      result.true_rank         <= b_res.rank;
      result.is_correct        <= b_res.correct;
      result.cell_count        <= b_res.label_ok ? OUT_CNT_W'(cell_new) : '0;
      result.tests_total       <= OUT_CNT_W'(st_next.tests);
      result.correct_total     <= OUT_CNT_W'(st_next.corrects);
      result.lowest_loss       <= st_next.min_loss;
      result.highest_loss      <= st_next.max_loss;
      result.loss_total        <= st_next.sum_loss;
      result.loss_square_total <= st_next.sum_sq;
    end
  end

  assign result.valid = c_valid;

endmodule
`default_nettype wire

[hw/rtl/crs_ram.sv]
`default_nettype none
module crs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/crs_rank.sv]
`default_nettype none
module crs_rank (
  input  wire crs_pkg::score_t   s [crs_pkg::NUM_CLASSES],
  input  wire crs_pkg::cls_t     label,
  output crs_pkg::rank_res_t     res
);
  import crs_pkg::*;

  score_t best;
  score_t ts;
  cls_t   pred;
  cls_t   rank;
  logic   ok;

  // first maximum
  always_comb begin
    best = s[0];
    pred = '0;
    for (int i = 1; i < NUM_CLASSES; i++) begin
      if (s[i] > best) begin
        best = s[i];
        pred = CLASS_W'(i);
      end
    end
  end

  assign ok = (label < CLASS_W'(NUM_CLASSES));

  always_comb begin
    ts = s[0];
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (CLASS_W'(i) == label) begin
        ts = s[i];
      end
    end
  end

  // strictly greater, or equal at a lower index
  always_comb begin
    rank = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if ((s[i] > ts) || ((s[i] == ts) && (CLASS_W'(i) < label))) begin
        rank = rank + CLASS_W'(1);
      end
    end
  end

  always_comb begin
    res.pred     = pred;
    res.label_ok = ok;
    res.rank     = ok ? rank : '0;
    res.correct  = ok && (pred == label);
    res.addr     = ok ? (CELL_AW'(rank) * CELL_AW'(NUM_CLASSES) + CELL_AW'(label)) : '0;
  end
endmodule
`default_nettype wire

[hw/rtl/crs_stats.sv]
`default_nettype none
module crs_stats (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          upd,
  input  wire logic                          label_ok,
  input  wire logic                          correct,
  input  wire logic [crs_pkg::LOSS_W-1:0]    loss,
  input  wire logic [crs_pkg::SQ_IN_W-1:0]   sq,
  output crs_pkg::stats_t                    nxt
);
  import crs_pkg::*;

  cnt_t              test_count;
  cnt_t              correct_count;
  logic [LOSS_W-1:0] min_loss;
  logic [LOSS_W-1:0] max_loss;
  logic [SUM_W-1:0]  sum_loss;
  logic [SQ_W-1:0]   sum_sq_loss;
  logic [SUM_W:0]    sum_wide;
  logic [SQ_W:0]     sq_wide;

  assign sum_wide = {1'b0, sum_loss} + (SUM_W+1)'(loss);
  assign sq_wide  = {1'b0, sum_sq_loss} + (SQ_W+1)'(sq);

  always_comb begin
    nxt.tests    = sat_inc(test_count);
    nxt.corrects = (label_ok && correct) ? sat_inc(correct_count) : correct_count;
    nxt.min_loss = (loss < min_loss) ? loss : min_loss;
    nxt.max_loss = (loss > max_loss) ? loss : max_loss;
    nxt.sum_loss = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    nxt.sum_sq   = sq_wide[SQ_W] ? '1 : sq_wide[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      test_count    <= '0;
      correct_count <= '0;
      min_loss      <= '1;
      max_loss      <= '0;
      sum_loss      <= '0;
      sum_sq_loss   <= '0;
    end else if (upd) begin
      test_count    <= nxt.tests;
      correct_count <= nxt.corrects;
      min_loss      <= nxt.min_loss;
      max_loss      <= nxt.max_loss;
      sum_loss      <= nxt.sum_loss;
      sum_sq_loss   <= nxt.sum_sq;
    end
  end
endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
// Rank statistics block: every word carries six scores, a label and a loss and
// yields one result word. A software copy of the statistics tracks every
// accepted input word, and each result word is checked against it in order.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crs_pkg::*;

  // Watchdog limit on cycles in which neither side moves a word. The slowest
  // correct stretch is the long receiver hold plus a few random gaps.
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_WORDS = 1630;
  // Receiver holds off once, after this many results, so the pipeline fills
  // and the block drops item.ready while the sender keeps offering.
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [SCORE_FIELDS-1:0][SCORE_FIELD_W-1:0] score;
    cls_t                                       label;
    logic [LOSS_W-1:0]                          loss;
  } sample_t;

  typedef struct packed {
    cls_t                 pred;
    cls_t                 rank;
    logic                 correct;
    logic [OUT_CNT_W-1:0] cell_cnt;
    logic [OUT_CNT_W-1:0] tests;
    logic [OUT_CNT_W-1:0] corrects;
    logic [LOSS_W-1:0]    low;
    logic [LOSS_W-1:0]    high;
    logic [SUM_W-1:0]     loss_sum;
    logic [SQ_W-1:0]      loss_sq_sum;
  } report_t;

  // Software copy of the statistics plus the queue of reports still owed.
  class rank_stats_tracker;
    cnt_t              cells[CELLS];
    cnt_t              tests;
    cnt_t              corrects;
    logic [LOSS_W-1:0] low;
    logic [LOSS_W-1:0] high;
    logic [SUM_W-1:0]  loss_sum;
    logic [SQ_W-1:0]   loss_sq_sum;
    report_t           owed[$];
    int                errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      tests       = '0;
      corrects    = '0;
      low         = '1;
      high        = '0;
      loss_sum    = '0;
      loss_sq_sum = '0;
      errors      = 0;
    endfunction

    function cnt_t bump(cnt_t c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    // Work out the report one accepted sample produces.
    function void record_sample(sample_t w);
      logic signed [SCORE_FIELD_W-1:0] s[NUM_CLASSES];
      logic [SUM_W:0]                  sum_next;
      logic [SQ_W:0]                   sq_next;
      report_t                         r;
      int                              ix;
      r = '0;
      for (int i = 0; i < NUM_CLASSES; i++) s[i] = w.score[i];
      // first highest score wins
      for (int i = 1; i < NUM_CLASSES; i++) begin
        if (s[i] > s[r.pred]) r.pred = cls_t'(i);
      end
      if (w.label < NUM_CLASSES) begin
        // strictly greater, or equal at a lower index
        for (int i = 0; i < NUM_CLASSES; i++) begin
          if (s[i] > s[w.label] || (s[i] == s[w.label] && i < w.label)) r.rank = r.rank + 1'b1;
        end
        r.correct = (r.pred == w.label);
        ix = r.rank * NUM_CLASSES + w.label;
        cells[ix] = bump(cells[ix]);
        r.cell_cnt = cells[ix];
        if (r.correct) corrects = bump(corrects);
      end
      tests = bump(tests);
      if (w.loss < low) low = w.loss;
      if (w.loss > high) high = w.loss;
      sum_next    = loss_sum + w.loss;
      loss_sum    = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
      sq_next     = loss_sq_sum + w.loss * w.loss;
      loss_sq_sum = sq_next[SQ_W] ? '1 : sq_next[SQ_W-1:0];
      r.tests       = tests;
      r.corrects    = corrects;
      r.low         = low;
      r.high        = high;
      r.loss_sum    = loss_sum;
      r.loss_sq_sum = loss_sq_sum;
      owed.insert(owed.size(), r);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (owed.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare("predicted_class", want.pred, got.pred);
      compare("true_rank", want.rank, got.rank);
      compare("is_correct", want.correct, got.correct);
      compare("cell_count", want.cell_cnt, got.cell_cnt);
      compare("tests_total", want.tests, got.tests);
      compare("correct_total", want.corrects, got.corrects);
      compare("lowest_loss", want.low, got.low);
      compare("highest_loss", want.high, got.high);
      compare("loss_total", want.loss_sum, got.loss_sum);
      compare("loss_square_total", want.loss_sq_sum, got.loss_sq_sum);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;   // when set, neither side idles
  int   idle_cycles;

  rank_stats_tracker tracker;

  crs_in_if  item ();
  crs_out_if result ();

  classifier_rank_statistics uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sample_t make_sample(int s0, int s1, int s2, int s3, int s4, int s5,
                                          int label, int loss);
    sample_t w;
    w.score[0] = 16'(s0);
    w.score[1] = 16'(s1);
    w.score[2] = 16'(s2);
    w.score[3] = 16'(s3);
    w.score[4] = 16'(s4);
    w.score[5] = 16'(s5);
    w.label    = cls_t'(label);
    w.loss     = 16'(loss);
    return w;
  endfunction

  // Crowded samples draw from a tiny set so ties between classes are common.
  function automatic logic [SCORE_FIELD_W-1:0] pick_score(bit crowded);
    if (!crowded) return 16'($urandom);
    case ($urandom_range(0, 6))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom_range(0, 4)) - 16'd2;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t w;
    bit      crowded;
    crowded = ($urandom_range(0, 9) < 4);
    for (int i = 0; i < SCORE_FIELDS; i++) w.score[i] = pick_score(crowded);
    // labels past the last class show up now and then
    w.label = ($urandom_range(0, 9) == 0) ? cls_t'($urandom_range(NUM_CLASSES, 7))
                                          : cls_t'($urandom_range(0, NUM_CLASSES - 1));
    case ($urandom_range(0, 19))
      0:       w.loss = '0;
      1:       w.loss = '1;
      default: w.loss = 16'($urandom);
    endcase
    return w;
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  task automatic send_sample(input sample_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid      <= 1'b1;
    item.score_0    <= w.score[0];
    item.score_1    <= w.score[1];
    item.score_2    <= w.score[2];
    item.score_3    <= w.score[3];
    item.score_4    <= w.score[4];
    item.score_5    <= w.score[5];
    item.true_label <= w.label;
    item.loss       <= w.loss;
    do @(posedge clk); while (!item.ready);
    tracker.record_sample(w);
  endtask

  // Result side: check each taken word, then pick the stall before the next.
  initial begin
    int      stall;
    int      taken;
    report_t got;
    stall = 0;
    taken = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result.valid && result.ready) begin
        got.pred        = result.predicted_class;
        got.rank        = result.true_rank;
        got.correct     = result.is_correct;
        got.cell_cnt    = result.cell_count;
        got.tests       = result.tests_total;
        got.corrects    = result.correct_total;
        got.low         = result.lowest_loss;
        got.high        = result.highest_loss;
        got.loss_sum    = result.loss_total;
        got.loss_sq_sum = result.loss_square_total;
        tracker.check_report(got);
        taken++;
        if (taken == HOLD_AT) stall = HOLD_CYCLES;
        else stall = steady ? 0 : $urandom_range(0, 4);
      end
      if (rst) begin
        result.ready <= 1'b0;
      end else if (stall > 0) begin
        result.ready <= 1'b0;
        stall--;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any cycle moving a word on either side resets the count.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item.valid && item.ready) || (result.valid && result.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    tracker = new();
    steady  = 1'b0;
    rst             <= 1'b1;
    item.valid      <= 1'b0;
    item.score_0    <= '0;
    item.score_1    <= '0;
    item.score_2    <= '0;
    item.score_3    <= '0;
    item.score_4    <= '0;
    item.score_5    <= '0;
    item.true_label <= '0;
    item.loss       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // all scores equal: first class predicted, label ranks by its index
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 5, 65535));
    // full-scale scores: last class on top, then all at the minimum and all at the maximum
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, 32767, 5, 1));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, 3, 'h8000));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 2, 'h00ff));
    // three-way tie at the top, label is the last of the tie
    send_sample(make_sample(100, 200, 200, 50, 200, -5, 4, 'h1234));
    // -1 against 0 across the sign boundary
    send_sample(make_sample(-1, 0, -1, 0, -1, 0, 3, 'h7fff));
    send_sample(make_sample(0, -1, 0, -1, 0, -1, 1, 2));
    // labels past the last class: no matrix update, rank and cell read zero
    send_sample(make_sample(5, 9, -3, 9, 0, 1, 6, 'hfffe));
    send_sample(make_sample(-7, -7, 12, 3, 12, 0, 7, 0));
    // each class predicted once, label on and off the winner
    for (int k = 0; k < NUM_CLASSES; k++) begin
      sample_t w;
      w = make_sample(-int'($urandom_range(1, 32768)), -int'($urandom_range(1, 32768)),
                      -int'($urandom_range(1, 32768)), -int'($urandom_range(1, 32768)),
                      -int'($urandom_range(1, 32768)), -int'($urandom_range(1, 32768)),
                      (k % 2 == 0) ? k : (k + 1) % NUM_CLASSES, $urandom_range(0, 65535));
      w.score[k] = 16'd256;
      send_sample(w);
    end
    send_sample(make_sample(1, 2, 3, 4, 5, 6, 0, 65535));
    send_sample(make_sample(6, 5, 4, 3, 2, 1, 5, 0));

    // --- random part, with a no-idle stretch every 250 words ---
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady = ((n % 250) >= 200);
      send_sample(random_sample());
    end
    steady = 1'b0;
    item.valid <= 1'b0;

    // drain: every owed report back, then a few cycles for strays
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
